/* rtl/emss_pkg.sv */
// ----------------------------------------------------------------------------
// emss_pkg
// Shared types and constants for the two-motor encoder step servo.
// ----------------------------------------------------------------------------
package emss_pkg;

    localparam int MOTORS         = 2;
    localparam int MOTOR_W        = $clog2(MOTORS);
    localparam int MAX_RESOLUTION = 4096;
    localparam int MIN_RESOLUTION = 4;
    localparam int RES_W          = 13;
    localparam int POS_W          = 12;
    localparam int OFF_W          = 12;
    localparam int STEP_W         = 14;
    localparam int DUTY_W         = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 13;

    localparam logic [RES_W-1:0] RES_RESET  = RES_W'(1024);
    localparam logic [OFF_W-1:0] OFF_RESET  = OFF_W'(5);
    localparam logic [DUTY_W-1:0] FBS_RESET = DUTY_W'(60);
    localparam logic [DUTY_W-1:0] VEL_RESET = DUTY_W'(150);

    // bit0 = dir_a, bit1 = dir_b
    localparam logic [1:0] PINS_FWD   = 2'b01;
    localparam logic [1:0] PINS_BWD   = 2'b10;
    localparam logic [1:0] PINS_BRAKE = 2'b11;
    localparam logic [1:0] PINS_OFF   = 2'b00;

    typedef enum logic [1:0] {
        OP_EDGE = 2'd0,
        OP_FWD  = 2'd1,
        OP_BWD  = 2'd2,
        OP_TICK = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENCODER_RES     = 3'd0,
        CFG_FEEDBACK_OFFSET = 3'd1,
        CFG_FEEDBACK_SPEED  = 3'd2,
        CFG_VELOCITY        = 3'd3,
        CFG_REVERSED_MASK   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [RES_W-1:0]  res;       // already clamped into range
        logic [OFF_W-1:0]  offset;
        logic [DUTY_W-1:0] fb_speed;
        logic [DUTY_W-1:0] velocity;
        logic [MOTORS-1:0] rev_mask;
    } cfg_t;

    typedef struct packed {
        logic [MOTOR_W-1:0] motor;
        logic [1:0]         pins;
        logic [DUTY_W-1:0]  duty;
        logic [POS_W-1:0]   position;
        logic               steps_done;
        logic               in_sync;
    } result_t;

endpackage

/* rtl/emss_cfg.sv */
// ----------------------------------------------------------------------------
// emss_cfg
// Configuration register file; resolution is clamped when written.
// ----------------------------------------------------------------------------
module emss_cfg
    import emss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic [RES_W-1:0] res_clamped;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (cfg_data[RES_W-1:0] < RES_W'(MIN_RESOLUTION))
            res_clamped = RES_W'(MIN_RESOLUTION);
        else if (cfg_data[RES_W-1:0] > RES_W'(MAX_RESOLUTION))
            res_clamped = RES_W'(MAX_RESOLUTION);
        else
            res_clamped = cfg_data[RES_W-1:0];
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ENCODER_RES:     cfg_next.res      = res_clamped;
                CFG_FEEDBACK_OFFSET: cfg_next.offset   = cfg_data[OFF_W-1:0];
                CFG_FEEDBACK_SPEED:  cfg_next.fb_speed = cfg_data[DUTY_W-1:0];
                CFG_VELOCITY:        cfg_next.velocity = cfg_data[DUTY_W-1:0];
                CFG_REVERSED_MASK:   cfg_next.rev_mask = cfg_data[MOTORS-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.res      <= RES_RESET;
            cfg_reg.offset   <= OFF_RESET;
            cfg_reg.fb_speed <= FBS_RESET;
            cfg_reg.velocity <= VEL_RESET;
            cfg_reg.rev_mask <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/emss_servo.sv */
// ----------------------------------------------------------------------------
// emss_servo
// Per-motor position, step count and drive state, with the single-pass
// update and the result for the addressed motor.
// ----------------------------------------------------------------------------
module emss_servo
    import emss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               upd,
    input  op_t                op,
    input  logic [MOTOR_W-1:0] motor,
    input  logic               phases_equal,
    output result_t            result
);

    logic [POS_W-1:0]  pos_reg   [MOTORS];
    logic [POS_W-1:0]  pos_next  [MOTORS];
    logic [STEP_W-1:0] steps_reg [MOTORS];
    logic [1:0]        pins_reg  [MOTORS];
    logic [DUTY_W-1:0] duty_reg  [MOTORS];

    logic [POS_W-1:0]  p;
    logic [RES_W-1:0]  p_inc;
    logic [POS_W-1:0]  p_new;
    logic [STEP_W-1:0] s_load;
    logic [STEP_W-1:0] s_new;
    logic [1:0]        pins_new;
    logic [DUTY_W-1:0] duty_new;
    logic              rev;
    logic [POS_W-1:0]  half;
    logic [STEP_W-1:0] res_minus_off;
    logic [1:0]        fb_pins;
    logic [DUTY_W-1:0] fb_duty;
    logic [RES_W-1:0]  d;
    logic [RES_W-1:0]  d_abs;
    logic [STEP_W-1:0] e;
    logic [STEP_W-1:0] e_abs;

    assign p    = pos_reg[motor];
    assign rev  = cfg.rev_mask[motor];
    assign half = cfg.res[RES_W-1:1];
    assign res_minus_off = {1'b0, cfg.res} - {2'b00, cfg.offset};

    // encoder edge: up wraps at or past resolution, down from zero wraps to res-1
    always_comb
    begin
        p_inc = {1'b0, p} + RES_W'(1);
        if (phases_equal)
            p_new = (p_inc >= cfg.res) ? '0 : p_inc[POS_W-1:0];
        else if (p == '0)
            p_new = POS_W'(cfg.res - RES_W'(1));
        else
            p_new = p - POS_W'(1);
    end

    // deadband feedback toward position zero
    always_comb
    begin
        if (p >= cfg.offset && p < half)
        begin
            fb_pins = PINS_FWD;
            fb_duty = cfg.fb_speed;
        end
        else if (!res_minus_off[STEP_W-1] && {2'b00, p} <= res_minus_off && p >= half)
        begin
            fb_pins = PINS_BWD;
            fb_duty = cfg.fb_speed;
        end
        else
        begin
            fb_pins = PINS_BRAKE;
            fb_duty = '0;
        end
    end

    always_comb
    begin
        case (op)
            OP_FWD:  s_load = {1'b0, cfg.res};
            OP_BWD:  s_load = ~{1'b0, cfg.res} + STEP_W'(1);
            OP_EDGE: s_load = steps_reg[motor];
            OP_TICK: s_load = steps_reg[motor];
        endcase

        if (op == OP_EDGE)
        begin
            s_new    = s_load;
            pins_new = pins_reg[motor];
            duty_new = duty_reg[motor];
        end
        else if (s_load[STEP_W-1])
        begin
            s_new    = s_load + STEP_W'(1);
            pins_new = rev ? PINS_FWD : PINS_BWD;
            duty_new = cfg.velocity;
        end
        else if (s_load != '0)
        begin
            s_new    = s_load - STEP_W'(1);
            pins_new = rev ? PINS_BWD : PINS_FWD;
            duty_new = cfg.velocity;
        end
        else
        begin
            s_new    = s_load;
            pins_new = fb_pins;
            duty_new = fb_duty;
        end
    end

    always_comb
    begin
        for (int m = 0; m < MOTORS; m++)
        begin
            if (op == OP_EDGE && motor == MOTOR_W'(m))
                pos_next[m] = p_new;
            else
                pos_next[m] = pos_reg[m];
        end
    end

    // sync check on the updated positions, also across the wrap point when motor 0 is the higher
    always_comb
    begin
        d     = {1'b0, pos_next[0]} - {1'b0, pos_next[1]};
        d_abs = d[RES_W-1] ? (~d + RES_W'(1)) : d;
        e     = {d[RES_W-1], d} - {1'b0, cfg.res};
        e_abs = e[STEP_W-1] ? (~e + STEP_W'(1)) : e;
    end

    always_comb
    begin
        result.motor      = motor;
        result.pins       = pins_new;
        result.duty       = duty_new;
        result.position   = pos_next[motor];
        result.steps_done = (s_new == '0);
        result.in_sync    = (d_abs < {1'b0, cfg.offset}) || (e_abs < {2'b00, cfg.offset});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < MOTORS; m++)
            begin
                pos_reg[m]   <= '0;
                steps_reg[m] <= '0;
                pins_reg[m]  <= PINS_OFF;
                duty_reg[m]  <= '0;
            end
        end
        else if (upd)
        begin
            for (int m = 0; m < MOTORS; m++)
                pos_reg[m] <= pos_next[m];
            steps_reg[motor] <= s_new;
            pins_reg[motor]  <= pins_new;
            duty_reg[motor]  <= duty_new;
        end
    end

endmodule

/* rtl/encoder_motor_step_servo.sv */
// ----------------------------------------------------------------------------
// encoder_motor_step_servo
// Two-motor quadrature position counter with step commands and feedback.
// ----------------------------------------------------------------------------
// Path: a request is accepted into the input register, then moves into the
//   result register, from which it is presented as a valid result.
// Throughput: one request per cycle while the result side is not stalled;
//   bounded by the read-modify-write of the per-motor state.
// Reset: rst_n clears positions, step counts, pins and duty to zero and
//   loads register defaults; no clearing pass.
module encoder_motor_step_servo
    import emss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            op,
    input  logic [MOTOR_W-1:0]    motor,
    input  logic                  phases_equal,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [MOTOR_W-1:0]    motor_out,
    output logic                  dir_a,
    output logic                  dir_b,
    output logic [DUTY_W-1:0]     duty,
    output logic [POS_W-1:0]      position,
    output logic                  steps_done,
    output logic                  in_sync,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t               cfg;
    logic               in_vld_reg;
    op_t                op_reg;
    logic [MOTOR_W-1:0] motor_reg;
    logic               peq_reg;
    logic               out_vld_reg;
    result_t            res_reg;
    result_t            res_next;
    logic               s2_load;

    assign s2_load  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || s2_load;

    emss_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    emss_servo u_servo (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .upd          (s2_load),
        .op           (op_reg),
        .motor        (motor_reg),
        .phases_equal (peq_reg),
        .result       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_vld_reg <= in_valid;
            if (s2_load)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg    <= op_t'(op);
            motor_reg <= motor;
            peq_reg   <= phases_equal;
        end
        if (s2_load)
            res_reg <= res_next;
    end

    assign out_valid  = out_vld_reg;
    assign motor_out  = res_reg.motor;
    assign dir_a      = res_reg.pins[0];
    assign dir_b      = res_reg.pins[1];
    assign duty       = res_reg.duty;
    assign position   = res_reg.position;
    assign steps_done = res_reg.steps_done;
    assign in_sync    = res_reg.in_sync;

endmodule

/* rtl/emss_checker.sv */
// ----------------------------------------------------------------------------
// emss_checker
// Port-level checks on the encoder step servo, bound to the top level.
// ----------------------------------------------------------------------------
module emss_checker
    import emss_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              dir_a,
    input logic              dir_b,
    input logic [DUTY_W-1:0] duty,
    input logic [POS_W-1:0]  position,
    input logic              steps_done
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(position) && $stable(duty))
        else $error("result changed while stalled");

    // brake and idle pins never carry duty
    a_brake_duty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (dir_a == dir_b) |-> duty == '0)
        else $error("duty nonzero with equal pins");

    // remaining steps imply a commanded drive
    a_steps_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !steps_done |-> dir_a != dir_b)
        else $error("steps pending without drive");

    // backpressure only from a held result
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output stall");

endmodule

bind encoder_motor_step_servo emss_checker u_emss_checker (.*);

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-motor encoder step servo. Requests go in
// on a valid/ready channel and are predicted by an in-bench servo model.
// Each result is compared field by field against the oldest prediction.
// The run covers directed corner cases and random traffic under several
// register settings, with random idling, stalls and one long receiver
// hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import emss_pkg::*;

    localparam int RESET_CYCLES = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 100;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 100;
    localparam int FILL_ITEMS   = 40;

    // index with no register behind it; a write must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    class servo_scoreboard;
        logic [RES_W-1:0]  res_reg;
        logic [OFF_W-1:0]  offset_reg;
        logic [DUTY_W-1:0] fb_speed_reg;
        logic [DUTY_W-1:0] velocity_reg;
        logic [MOTORS-1:0] rev_mask_reg;
        logic [POS_W-1:0]  pos_q[MOTORS];
        int                steps_q[MOTORS];
        logic [1:0]        pins_q[MOTORS];
        logic [DUTY_W-1:0] duty_q[MOTORS];
        result_t           expected_q[$];
        int                errors;

        function new();
            res_reg      = RES_RESET;
            offset_reg   = OFF_RESET;
            fb_speed_reg = FBS_RESET;
            velocity_reg = VEL_RESET;
            rev_mask_reg = '0;
            for (int m = 0; m < MOTORS; m++)
            begin
                pos_q[m]   = '0;
                steps_q[m] = 0;
                pins_q[m]  = PINS_OFF;
                duty_q[m]  = '0;
            end
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int clamped_res();
            int r;
            r = res_reg;
            if (r < MIN_RESOLUTION)
                r = MIN_RESOLUTION;
            if (r > MAX_RESOLUTION)
                r = MAX_RESOLUTION;
            return r;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ENCODER_RES:     res_reg      = data[RES_W-1:0];
                CFG_FEEDBACK_OFFSET: offset_reg   = data[OFF_W-1:0];
                CFG_FEEDBACK_SPEED:  fb_speed_reg = data[DUTY_W-1:0];
                CFG_VELOCITY:        velocity_reg = data[DUTY_W-1:0];
                CFG_REVERSED_MASK:   rev_mask_reg = data[MOTORS-1:0];
                default: ;
            endcase
        endfunction

        function logic [1:0] run_pins(int m, logic fwd);
            return (fwd != rev_mask_reg[m]) ? PINS_FWD : PINS_BWD;
        endfunction

        // deadband pull toward position zero; reversal does not apply here
        function void settle(int m);
            int res;
            int p;
            int off;
            int half;
            res  = clamped_res();
            p    = pos_q[m];
            off  = offset_reg;
            half = res / 2;
            if (p >= off && p < half)
            begin
                pins_q[m] = PINS_FWD;
                duty_q[m] = fb_speed_reg;
            end
            else if (p <= res - off && p >= half)
            begin
                pins_q[m] = PINS_BWD;
                duty_q[m] = fb_speed_reg;
            end
            else
            begin
                pins_q[m] = PINS_BRAKE;
                duty_q[m] = '0;
            end
        endfunction

        function void control_tick(int m);
            if (steps_q[m] > 0)
            begin
                pins_q[m] = run_pins(m, 1'b1);
                duty_q[m] = velocity_reg;
                steps_q[m]--;
            end
            else if (steps_q[m] < 0)
            begin
                pins_q[m] = run_pins(m, 1'b0);
                duty_q[m] = velocity_reg;
                steps_q[m]++;
            end
            else
                settle(m);
        endfunction

        // position may sit above the resolution after a register change
        function void count_edge(int m, logic up);
            int res;
            int p;
            res = clamped_res();
            p   = pos_q[m];
            if (up)
            begin
                p = p + 1;
                if (p >= res)
                    p = 0;
            end
            else
                p = (p == 0) ? res - 1 : p - 1;
            pos_q[m] = POS_W'(p);
        endfunction

        function logic positions_agree();
            int d;
            int e;
            int off;
            d   = int'(pos_q[0]) - int'(pos_q[1]);
            e   = d - clamped_res();
            off = offset_reg;
            return (((d < 0) ? -d : d) < off) || (((e < 0) ? -e : e) < off);
        endfunction

        function void note_request(op_t code, int m, logic peq);
            result_t want;
            case (code)
                OP_EDGE: count_edge(m, peq);
                OP_FWD:
                begin
                    steps_q[m] = clamped_res();
                    control_tick(m);
                end
                OP_BWD:
                begin
                    steps_q[m] = -clamped_res();
                    control_tick(m);
                end
                default: control_tick(m);
            endcase
            want.motor      = MOTOR_W'(m);
            want.pins       = pins_q[m];
            want.duty       = duty_q[m];
            want.position   = pos_q[m];
            want.steps_done = (steps_q[m] == 0);
            want.in_sync    = positions_agree();
            expected_q.push_back(want);
        endfunction

        function void compare(string what, logic [15:0] want_v, logic [15:0] got_v);
            if (got_v !== want_v)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch: expected %0d, actual %0d",
                             $time, what, want_v, got_v);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with no request pending: expected none, actual position %0d",
                         $time, got.position);
                return;
            end
            want = expected_q.pop_front();
            compare("motor_out", want.motor, got.motor);
            compare("dir_a", want.pins[0], got.pins[0]);
            compare("dir_b", want.pins[1], got.pins[1]);
            compare("duty", want.duty, got.duty);
            compare("position", want.position, got.position);
            compare("steps_done", want.steps_done, got.steps_done);
            compare("in_sync", want.in_sync, got.in_sync);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            op;
    logic [MOTOR_W-1:0]    motor;
    logic                  phases_equal;
    logic                  out_valid;
    logic                  out_ready;
    logic [MOTOR_W-1:0]    motor_out;
    logic                  dir_a;
    logic                  dir_b;
    logic [DUTY_W-1:0]     duty;
    logic [POS_W-1:0]      position;
    logic                  steps_done;
    logic                  in_sync;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    servo_scoreboard book = new();
    result_t         seen;
    int              send_idle_pct;
    int              recv_stall_pct;
    logic            hold_off_req;
    int              quiet_cycles;

    encoder_motor_step_servo dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .motor        (motor),
        .phases_equal (phases_equal),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .motor_out    (motor_out),
        .dir_a        (dir_a),
        .dir_b        (dir_b),
        .duty         (duty),
        .position     (position),
        .steps_done   (steps_done),
        .in_sync      (in_sync),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen.motor      = motor_out;
            seen.pins       = {dir_b, dir_a};
            seen.duty       = duty;
            seen.position   = position;
            seen.steps_done = steps_done;
            seen.in_sync    = in_sync;
            book.check_result(seen);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready    = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
                out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_request(op_t code, logic m, logic peq);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid     = 1'b1;
        op           = code;
        motor        = m;
        phases_equal = peq;
        do @(posedge clk); while (!in_ready);
        book.note_request(code, m, peq);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        book.set_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // mostly encoder edges and ticks; commands are rare so step counts
    // run out and the deadband logic gets exercised
    task automatic random_burst(int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
                send_request(OP_FWD, 1'($urandom_range(1)), 1'($urandom_range(1)));
            else if (pick < 6)
                send_request(OP_BWD, 1'($urandom_range(1)), 1'($urandom_range(1)));
            else if (pick < 52)
                send_request(OP_EDGE, 1'($urandom_range(1)), 1'($urandom_range(1)));
            else
                send_request(OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    task automatic random_settings();
        int r;
        logic [CFG_DATA_W-1:0] res_val;
        r = $urandom_range(9);
        if (r == 0)
            res_val = CFG_DATA_W'($urandom_range(MIN_RESOLUTION - 1));
        else if (r == 1)
            res_val = CFG_DATA_W'($urandom_range(8191, MAX_RESOLUTION));
        else if (r < 4)
            res_val = CFG_DATA_W'($urandom_range(64, 13));
        else
            res_val = CFG_DATA_W'($urandom_range(12, MIN_RESOLUTION));
        write_reg(CFG_ENCODER_RES, res_val);
        r = $urandom_range(9);
        if (r == 0)
            write_reg(CFG_FEEDBACK_OFFSET, CFG_DATA_W'($urandom_range(4095)));
        else if (r == 1)
            write_reg(CFG_FEEDBACK_OFFSET, 0);
        else
            write_reg(CFG_FEEDBACK_OFFSET,
                      CFG_DATA_W'($urandom_range(book.clamped_res() / 2 + 1)));
        write_reg(CFG_FEEDBACK_SPEED, CFG_DATA_W'($urandom_range(255)));
        write_reg(CFG_VELOCITY, CFG_DATA_W'($urandom_range(255)));
        write_reg(CFG_REVERSED_MASK, CFG_DATA_W'($urandom_range(3)));
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        op             = OP_EDGE;
        motor          = '0;
        phases_equal   = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_ENCODER_RES;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: brake at zero, wrap both ways, commands
        send_request(OP_TICK, 1'b0, 1'b1);
        send_request(OP_EDGE, 1'b0, 1'b0);
        send_request(OP_EDGE, 1'b0, 1'b1);
        send_request(OP_EDGE, 1'b0, 1'b0);
        send_request(OP_EDGE, 1'b1, 1'b1);
        send_request(OP_FWD, 1'b1, 1'b0);
        send_request(OP_BWD, 1'b0, 1'b1);
        send_request(OP_TICK, 1'b1, 1'b0);
        wait_idle();

        // motor 0 now sits far above the new resolution
        write_reg(CFG_ENCODER_RES, 8);
        send_request(OP_EDGE, 1'b0, 1'b0);
        send_request(OP_EDGE, 1'b0, 1'b1);
        wait_idle();

        // reversed pins, then deadband wider than the resolution
        write_reg(CFG_FEEDBACK_OFFSET, 2048);
        write_reg(CFG_REVERSED_MASK, 3);
        write_reg(CFG_VELOCITY, 255);
        write_reg(CFG_FEEDBACK_SPEED, 255);
        send_request(OP_FWD, 1'b0, 1'b0);
        send_request(OP_BWD, 1'b1, 1'b1);
        repeat (8) send_request(OP_TICK, 1'b0, 1'b0);
        wait_idle();

        // resolution below the floor, zero deadband and zero duties
        write_reg(CFG_ENCODER_RES, 0);
        write_reg(CFG_FEEDBACK_OFFSET, 0);
        write_reg(CFG_VELOCITY, 0);
        write_reg(CFG_FEEDBACK_SPEED, 0);
        write_reg(CFG_REVERSED_MASK, 0);
        send_request(OP_EDGE, 1'b0, 1'b1);
        send_request(OP_TICK, 1'b0, 1'b0);
        send_request(OP_TICK, 1'b1, 1'b1);
        wait_idle();

        // resolution above the ceiling, widest deadband
        write_reg(CFG_ENCODER_RES, 8191);
        write_reg(CFG_FEEDBACK_OFFSET, 4095);
        write_reg(CFG_SPARE, 8191);
        send_request(OP_EDGE, 1'b1, 1'b0);
        send_request(OP_TICK, 1'b0, 1'b0);
        send_request(OP_EDGE, 1'b0, 1'b0);
        send_request(OP_EDGE, 1'b0, 1'b0);
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            random_settings();
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 54;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 54;
                end
                default:
                begin
                    send_idle_pct  = 20;
                    recv_stall_pct = 20;
                end
            endcase
            random_burst(PHASE_ITEMS);
            wait_idle();
        end

        // back-pressure: result side frozen while requests keep coming
        random_settings();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = 1'b1;
        random_burst(FILL_ITEMS);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (book.errors == 0 && book.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
